// ===== src/ber_tlv_stream_parser_defines.svh =====
// Assertion macros shared by the parser RTL.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef BER_TLV_STREAM_PARSER_DEFINES_SVH
`define BER_TLV_STREAM_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication: when ante holds, cons must hold.
`define BTSP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define BTSP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BTSP_ASSERT_IMP(label, ante, cons, msg)

`define BTSP_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

// ===== src/btsp_pkg.sv =====
package btsp_pkg;

  localparam int MAX_DEPTH     = 8;
  localparam int MAX_TAG_BYTES = 4;
  localparam int MAX_LEN_BYTES = 4;

  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
  localparam int IDX_W   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int TCNT_W  = $clog2(MAX_TAG_BYTES + 1);
  localparam int LCNT_W  = $clog2(MAX_LEN_BYTES + 1);

  // Parser phases.
  localparam logic [2:0] PH_TAG_FIRST = 3'd0;
  localparam logic [2:0] PH_TAG_MORE  = 3'd1;
  localparam logic [2:0] PH_LEN_FIRST = 3'd2;
  localparam logic [2:0] PH_LEN_MORE  = 3'd3;
  localparam logic [2:0] PH_VALUE     = 3'd4;

  // Event codes.
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_HEADER = 2'd1;
  localparam logic [1:0] EV_VALUE  = 2'd2;
  localparam logic [1:0] EV_ERROR  = 2'd3;

  // Error codes.
  localparam logic [1:0] ERR_TRUNC    = 2'd0;
  localparam logic [1:0] ERR_OVERRUN  = 2'd1;
  localparam logic [1:0] ERR_TOO_DEEP = 2'd2;
  localparam logic [1:0] ERR_TOO_LONG = 2'd3;

  // Bit fields of tag and length bytes.
  localparam logic [7:0] TAG_NUM_MASK = 8'h1F;
  localparam logic [7:0] CONT_BIT     = 8'h80;
  localparam logic [7:0] LEN_MASK     = 8'h7F;
  localparam logic [7:0] CONS_BIT     = 8'h20;

  typedef struct packed {
    logic [1:0]         event_res;
    logic [31:0]        tag;
    logic [2:0]         tag_bytes;
    logic [31:0]        length;
    logic               constructed;
    logic [DEPTH_W-1:0] depth;
    logic [7:0]         value_byte;
    logic               value_last;
    logic [DEPTH_W-1:0] closed_levels;
    logic [1:0]         error_kind;
    logic               message_done;
  } res_t;

  typedef struct packed {
    logic               clear;
    logic               push;
    logic [31:0]        push_end;
    logic [DEPTH_W-1:0] pop_cnt;
  } stk_cmd_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [31:0]        top_end;
    logic [DEPTH_W-1:0] close_cnt;
  } stk_stat_t;

endpackage

// ===== src/btsp_ifs.sv =====
interface btsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface btsp_out_if;
  import btsp_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         event_res;
  logic [31:0]        tag;
  logic [2:0]         tag_bytes;
  logic [31:0]        length;
  logic               constructed;
  logic [DEPTH_W-1:0] depth;
  logic [7:0]         value_byte;
  logic               value_last;
  logic [DEPTH_W-1:0] closed_levels;
  logic [1:0]         error_kind;
  logic               message_done;

  modport source (output valid, output event_res, output tag, output tag_bytes,
                  output length, output constructed, output depth, output value_byte,
                  output value_last, output closed_levels, output error_kind,
                  output message_done, input ready);
  modport sink   (input valid, input event_res, input tag, input tag_bytes,
                  input length, input constructed, input depth, input value_byte,
                  input value_last, input closed_levels, input error_kind,
                  input message_done, output ready);
endinterface

// ===== src/ber_tlv_stream_parser.sv =====
// Channel   Direction  Words
// in_chan   in         in_byte, last_byte: one message byte per word
// out_chan  out        event_res ... message_done: one result word per input word
//
// Every input word gives exactly one result word, in order.
// Words pass the input and then the result register; one per cycle unless out stalls.
// The rate is set by the single pass through the parser logic, where the open-container
// ends are all compared against the next position in parallel.
// Reset (rst_n low, synchronous) empties both register stages and returns the parser to
// the first tag byte of a new message.
// A stalled result holds its word while the input register can still take one more word.

module ber_tlv_stream_parser (
  input  logic       clk,
  input  logic       rst_n,
  btsp_in_if.sink    in_chan,
  btsp_out_if.source out_chan
);
  import btsp_pkg::*;

  // Input register stage handshake and held byte.
  logic       in_vld;
  logic [7:0] in_data;
  logic       in_last;

  // The held byte advances when the result register is free to take its result.
  logic       out_free;
  logic       take;

  // Stack of container end positions and its summary toward the parser.
  stk_cmd_t   stk_cmd;
  stk_stat_t  stk_stat;
  logic [31:0] match_pos;

  res_t       res;

  assign take = in_vld && out_free;

  btsp_in_stage u_in (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .take    (take),
    .vld     (in_vld),
    .data    (in_data),
    .last    (in_last)
  );

  // Stack changes only when a word is processed; else clear, push and pop_cnt are zero.
  btsp_stack u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (stk_cmd),
    .match_pos (match_pos),
    .stat      (stk_stat)
  );

  btsp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (take),
    .data      (in_data),
    .last      (in_last),
    .stat      (stk_stat),
    .cmd       (stk_cmd),
    .match_pos (match_pos),
    .res       (res)
  );

  btsp_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (take),
    .res      (res),
    .free     (out_free),
    .out_chan (out_chan)
  );

endmodule

// ===== src/btsp_in_stage.sv =====
module btsp_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  btsp_in_if.sink    in_chan,
  input  logic       take,
  output logic       vld,
  output logic [7:0] data,
  output logic       last
);

  logic       vld_r, vld_nxt;
  logic [7:0] data_r;
  logic       last_r;
  logic       load;

  assign in_chan.ready = !vld_r || take;
  assign load          = in_chan.valid && in_chan.ready;
  assign vld_nxt       = load ? 1'b1 : (take ? 1'b0 : vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_chan.in_byte;
      last_r <= in_chan.last_byte;
    end
  end

  assign vld  = vld_r;
  assign data = data_r;
  assign last = last_r;

endmodule

// ===== src/btsp_stack.sv =====
`include "ber_tlv_stream_parser_defines.svh"

module btsp_stack (
  input  logic                clk,
  input  logic                rst_n,
  input  btsp_pkg::stk_cmd_t  cmd,
  input  logic [31:0]         match_pos,
  output btsp_pkg::stk_stat_t stat
);
  import btsp_pkg::*;

  logic [31:0]        end_r [MAX_DEPTH];
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [DEPTH_W-1:0] top_idx;
  logic [DEPTH_W-1:0] cnt;

  // Ends are non-increasing from bottom to top, so the entries equal to the
  // probe position form a run at the top and a plain count gives the pops.
  always_comb begin
    cnt = '0;
    for (int k = 0; k < MAX_DEPTH; k++) begin
      if ((DEPTH_W'(k) < depth_r) && (end_r[k] == match_pos)) begin
        cnt = cnt + DEPTH_W'(1);
      end
    end
  end

  assign top_idx = depth_r - DEPTH_W'(1);

  always_comb begin
    if (cmd.clear) begin
      depth_nxt = '0;
    end else if (cmd.push) begin
      depth_nxt = depth_r + DEPTH_W'(1);
    end else begin
      depth_nxt = depth_r - cmd.pop_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else begin
      depth_r <= depth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && !cmd.clear) begin
      end_r[depth_r[IDX_W-1:0]] <= cmd.push_end;
    end
  end

  assign stat.depth     = depth_r;
  assign stat.top_end   = end_r[top_idx[IDX_W-1:0]];
  assign stat.close_cnt = cnt;

  `BTSP_ASSERT_IMP(a_push_not_full, cmd.push && !cmd.clear, depth_r < DEPTH_W'(MAX_DEPTH), "push onto a full stack")
  `BTSP_ASSERT_IMP(a_pop_in_range, !cmd.clear, cmd.pop_cnt <= depth_r, "pop below an empty stack")

endmodule

// ===== src/btsp_core.sv =====
`include "ber_tlv_stream_parser_defines.svh"

module btsp_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          data,
  input  logic                last,
  input  btsp_pkg::stk_stat_t stat,
  output btsp_pkg::stk_cmd_t  cmd,
  output logic [31:0]         match_pos,
  output btsp_pkg::res_t      res
);
  import btsp_pkg::*;

  logic [2:0]        phase_r, phase_nxt;
  logic [31:0]       tag_acc_r, tag_acc_nxt;
  logic [TCNT_W-1:0] tag_cnt_r, tag_cnt_nxt;
  logic [31:0]       len_acc_r, len_acc_nxt;
  logic [LCNT_W-1:0] len_left_r, len_left_nxt;
  logic [31:0]       val_left_r, val_left_nxt;
  logic [31:0]       pos_r, pos_nxt;
  logic              failed_r, failed_nxt;
  logic              cons_r, cons_nxt;

  logic [31:0]        next_pos;
  logic [32:0]        end_pos;
  logic [6:0]         len_n;
  logic               err, hdr, complete, push, done;
  logic [1:0]         err_code, ev;
  logic [DEPTH_W-1:0] closed, pops, depth_after;
  logic               vlast;
  logic               restart;

  assign next_pos  = pos_r + 32'd1;
  assign match_pos = next_pos;
  assign restart   = step && last;
  assign len_n     = data[6:0];
  assign end_pos   = {1'b0, pos_r} + 33'd1 + {1'b0, len_acc_nxt};

  always_comb begin
    phase_nxt    = phase_r;
    tag_acc_nxt  = tag_acc_r;
    tag_cnt_nxt  = tag_cnt_r;
    len_acc_nxt  = len_acc_r;
    len_left_nxt = len_left_r;
    val_left_nxt = val_left_r;
    cons_nxt     = cons_r;
    failed_nxt   = failed_r;
    pos_nxt      = pos_r;
    err          = 1'b0;
    err_code     = ERR_TRUNC;
    hdr          = 1'b0;
    complete     = 1'b0;
    push         = 1'b0;
    done         = 1'b0;
    ev           = EV_NONE;
    vlast        = 1'b0;
    closed       = '0;
    pops         = '0;
    depth_after  = stat.depth;
    res          = '0;

    if (step && !failed_r) begin
      pos_nxt = next_pos;
      if ((phase_r != PH_VALUE) && (stat.depth != '0) && (pos_r >= stat.top_end)) begin
        // A header byte at or past the end of the open container.
        err      = 1'b1;
        err_code = ERR_OVERRUN;
      end else begin
        case (phase_r)
          PH_TAG_FIRST: begin
            tag_acc_nxt = {24'd0, data};
            tag_cnt_nxt = TCNT_W'(1);
            cons_nxt    = (data & CONS_BIT) != 8'd0;
            phase_nxt   = ((data & TAG_NUM_MASK) == TAG_NUM_MASK) ? PH_TAG_MORE : PH_LEN_FIRST;
          end
          PH_TAG_MORE: begin
            if (tag_cnt_r >= TCNT_W'(MAX_TAG_BYTES)) begin
              err      = 1'b1;
              err_code = ERR_TOO_LONG;
            end else begin
              tag_acc_nxt = {tag_acc_r[23:0], data};
              tag_cnt_nxt = tag_cnt_r + TCNT_W'(1);
              if ((data & CONT_BIT) == 8'd0) begin
                phase_nxt = PH_LEN_FIRST;
              end
            end
          end
          PH_LEN_FIRST: begin
            if ((data & CONT_BIT) == 8'd0) begin
              len_acc_nxt = {25'd0, len_n};
              hdr         = 1'b1;
            end else begin
              len_acc_nxt = '0;
              if (len_n > 7'(MAX_LEN_BYTES)) begin
                err      = 1'b1;
                err_code = ERR_TOO_LONG;
              end else if (len_n == 7'd0) begin
                hdr = 1'b1;
              end else begin
                len_left_nxt = LCNT_W'(len_n);
                phase_nxt    = PH_LEN_MORE;
              end
            end
          end
          PH_LEN_MORE: begin
            if (len_acc_r[31:24] != 8'd0) begin
              err      = 1'b1;
              err_code = ERR_TOO_LONG;
            end else begin
              len_acc_nxt  = {len_acc_r[23:0], data};
              len_left_nxt = (len_left_r != '0) ? len_left_r - LCNT_W'(1) : len_left_r;
              if (len_left_nxt == '0) begin
                hdr = 1'b1;
              end
            end
          end
          default: begin
            // Primitive value byte.
            ev           = EV_VALUE;
            val_left_nxt = (val_left_r != '0) ? val_left_r - 32'd1 : val_left_r;
            if (val_left_nxt == '0) begin
              vlast     = 1'b1;
              complete  = 1'b1;
              phase_nxt = PH_TAG_FIRST;
            end
          end
        endcase
      end

      if (hdr) begin
        if ((stat.depth != '0) && (end_pos > {1'b0, stat.top_end})) begin
          err      = 1'b1;
          err_code = ERR_OVERRUN;
        end else if (end_pos[32]) begin
          err      = 1'b1;
          err_code = ERR_TRUNC;
        end else if (cons_r && (stat.depth >= DEPTH_W'(MAX_DEPTH))) begin
          err      = 1'b1;
          err_code = ERR_TOO_DEEP;
        end else begin
          ev        = EV_HEADER;
          phase_nxt = PH_TAG_FIRST;
          if (cons_r) begin
            if (len_acc_nxt == '0) begin
              // An empty container opens and closes on this byte.
              closed   = DEPTH_W'(1);
              complete = 1'b1;
            end else begin
              push = 1'b1;
            end
          end else if (len_acc_nxt == '0) begin
            complete = 1'b1;
          end else begin
            val_left_nxt = len_acc_nxt;
            phase_nxt    = PH_VALUE;
          end
        end
      end

      if (!err && complete) begin
        pops   = stat.close_cnt;
        closed = closed + stat.close_cnt;
      end
      depth_after = stat.depth - pops + (push ? DEPTH_W'(1) : DEPTH_W'(0));

      if (last && !err) begin
        if ((phase_nxt != PH_TAG_FIRST) || (depth_after != '0)) begin
          err      = 1'b1;
          err_code = ERR_TRUNC;
        end else begin
          done = 1'b1;
        end
      end

      if (err) begin
        failed_nxt     = 1'b1;
        res.event_res  = EV_ERROR;
        res.depth      = stat.depth;
        res.error_kind = err_code;
      end else begin
        res.event_res = ev;
        if (ev == EV_HEADER) begin
          res.tag         = tag_acc_nxt;
          res.tag_bytes   = 3'(tag_cnt_nxt);
          res.length      = len_acc_nxt;
          res.constructed = cons_r;
        end
        res.depth         = stat.depth;
        res.value_byte    = (ev == EV_VALUE) ? data : 8'd0;
        res.value_last    = vlast;
        res.closed_levels = closed;
        res.message_done  = done;
      end
    end else if (step) begin
      pos_nxt = next_pos;
    end
  end

  assign cmd.clear    = restart;
  assign cmd.push     = push && !err;
  assign cmd.push_end = end_pos[31:0];
  assign cmd.pop_cnt  = err ? '0 : pops;

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      phase_r    <= PH_TAG_FIRST;
      tag_acc_r  <= '0;
      tag_cnt_r  <= '0;
      len_acc_r  <= '0;
      len_left_r <= '0;
      val_left_r <= '0;
      pos_r      <= '0;
      failed_r   <= 1'b0;
      cons_r     <= 1'b0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      tag_acc_r  <= tag_acc_nxt;
      tag_cnt_r  <= tag_cnt_nxt;
      len_acc_r  <= len_acc_nxt;
      len_left_r <= len_left_nxt;
      val_left_r <= val_left_nxt;
      pos_r      <= pos_nxt;
      failed_r   <= failed_nxt;
      cons_r     <= cons_nxt;
    end
  end

  `BTSP_ASSERT_NXT(a_err_latches, step && !last && (res.event_res == EV_ERROR), failed_r, "error did not latch")
  `BTSP_ASSERT_IMP(a_failed_quiet, step && failed_r, (res.event_res == EV_NONE) && (res.depth == '0), "output while ignoring bytes")

endmodule

// ===== src/btsp_out_stage.sv =====
module btsp_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  btsp_pkg::res_t res,
  output logic           free,
  btsp_out_if.source     out_chan
);
  import btsp_pkg::*;

  logic vld_r, vld_nxt;
  res_t res_r;

  assign free    = !vld_r || out_chan.ready;
  assign vld_nxt = load ? 1'b1 : (out_chan.ready ? 1'b0 : vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_chan.valid         = vld_r;
  assign out_chan.event_res     = res_r.event_res;
  assign out_chan.tag           = res_r.tag;
  assign out_chan.tag_bytes     = res_r.tag_bytes;
  assign out_chan.length        = res_r.length;
  assign out_chan.constructed   = res_r.constructed;
  assign out_chan.depth         = res_r.depth;
  assign out_chan.value_byte    = res_r.value_byte;
  assign out_chan.value_last    = res_r.value_last;
  assign out_chan.closed_levels = res_r.closed_levels;
  assign out_chan.error_kind    = res_r.error_kind;
  assign out_chan.message_done  = res_r.message_done;

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import btsp_pkg::*;

  // A message under construction, one raw byte per entry.
  typedef logic [7:0] bytes_t[$];

  // One word of the byte channel as the driver keeps it.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_word_t;

  localparam int RANDOM_BYTES_PER_STAGE = 550;
  localparam int HOLD_OFF_CYCLES        = 300;
  localparam int WATCHDOG_LIMIT         = 3000;
  localparam int DRAIN_CYCLES           = 8;

  // Directed messages. Bit 8 of each entry marks the final byte of its message.
  localparam logic [8:0] DIRECTED_WORDS [32] = '{
    // Primitive element with a zero tag and a zero length.
    9'h000, 9'h100,
    // Four-byte tag DF FF FF 7F, long form length of one, value byte FF.
    9'h0DF, 9'h0FF, 9'h0FF, 9'h07F, 9'h081, 9'h001, 9'h1FF,
    // The tag runs on past four bytes; the failing byte is also the last one.
    9'h01F, 9'h080, 9'h080, 9'h080, 9'h180,
    // Long form count above the limit, then a byte that must be ignored.
    9'h024, 9'h085, 9'h100,
    // A four-byte length of FFFFFFFF runs past the end of the position range.
    9'h004, 9'h084, 9'h0FF, 9'h0FF, 9'h0FF, 9'h1FF,
    // A child whose value would end past its parent container.
    9'h030, 9'h002, 9'h020, 9'h105,
    // Empty constructed element given with the 0x80 length byte.
    9'h020, 9'h180,
    // The message stops in the middle of a primitive value.
    9'h004, 9'h002, 9'h1AA
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  btsp_in_if  in_if();
  btsp_out_if out_if();

  ber_tlv_stream_parser u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Byte words waiting for the driver, and result words still owed by the block.
  stream_word_t byte_backlog[$];
  res_t         pending_results[$];

  // Handshake bookkeeping shared between the clocked processes. in_took and offering
  // are written at one clock edge and read at the other, so no ordering issue arises.
  logic         in_took;
  logic         offering;
  stream_word_t cur_word;
  int           send_idle_pct;
  int           take_idle_pct;
  logic         hold_req;
  int           hold_left;
  int           stall_cycles;
  int           fail_count;

  initial begin
    in_took       = 1'b0;
    offering      = 1'b0;
    cur_word      = '0;
    send_idle_pct = 0;
    take_idle_pct = 0;
    hold_req      = 1'b0;
    hold_left     = 0;
    stall_cycles  = 0;
    fail_count    = 0;
  end

  // ---------------------------------------------------------------------------
  // Parser state as the testbench tracks it. The container end stack is only
  // ever read below open_levels, so it needs no clearing.
  // ---------------------------------------------------------------------------
  logic [2:0]  cur_phase;
  logic [31:0] tag_word;
  int          tag_count;
  logic [31:0] len_word;
  int          len_bytes_left;
  logic [31:0] value_left;
  logic [31:0] byte_pos;
  int          open_levels;
  logic [31:0] close_at [MAX_DEPTH];
  logic        in_error;
  logic        hdr_constructed;

  function automatic void parser_idle();
    cur_phase       = PH_TAG_FIRST;
    tag_word        = '0;
    tag_count       = 0;
    len_word        = '0;
    len_bytes_left  = 0;
    value_left      = '0;
    byte_pos        = '0;
    open_levels     = 0;
    in_error        = 1'b0;
    hdr_constructed = 1'b0;
  endfunction

  // Advances the tracked parser by one byte and returns the result word that the
  // block must produce for it.
  function automatic res_t parse_byte(logic [7:0] b, logic last);
    res_t        r;
    logic [31:0] here;
    logic [31:0] nxt;
    logic [32:0] end_pos;
    int          dep;
    int          closed;
    logic        hdr;
    logic        complete;
    logic        err;
    logic [1:0]  err_kind;
    logic [1:0]  ev;
    logic [7:0]  vbyte;
    logic        vlast;
    logic        done;
    r        = '0;
    here     = byte_pos;
    nxt      = byte_pos + 32'd1;
    dep      = open_levels;
    closed   = 0;
    hdr      = 1'b0;
    complete = 1'b0;
    err      = 1'b0;
    err_kind = ERR_TRUNC;
    ev       = EV_NONE;
    vbyte    = '0;
    vlast    = 1'b0;
    done     = 1'b0;
    byte_pos = nxt;

    // After an error everything up to the end of the message is swallowed.
    if (in_error) begin
      if (last) parser_idle();
      return r;
    end

    if (cur_phase != PH_VALUE && open_levels > 0 && here >= close_at[open_levels-1]) begin
      // A new header may not start at or past the end of its container.
      err      = 1'b1;
      err_kind = ERR_OVERRUN;
    end else if (cur_phase == PH_TAG_FIRST) begin
      tag_word        = {24'd0, b};
      tag_count       = 1;
      hdr_constructed = (b & CONS_BIT) != 0;
      cur_phase       = ((b & TAG_NUM_MASK) == TAG_NUM_MASK) ? PH_TAG_MORE : PH_LEN_FIRST;
    end else if (cur_phase == PH_TAG_MORE) begin
      if (tag_count >= MAX_TAG_BYTES) begin
        err      = 1'b1;
        err_kind = ERR_TOO_LONG;
      end else begin
        tag_word  = {tag_word[23:0], b};
        tag_count = tag_count + 1;
        if ((b & CONT_BIT) == 0) cur_phase = PH_LEN_FIRST;
      end
    end else if (cur_phase == PH_LEN_FIRST) begin
      if ((b & CONT_BIT) == 0) begin
        len_word = {24'd0, b & LEN_MASK};
        hdr      = 1'b1;
      end else begin
        len_word = '0;
        if (int'(b & LEN_MASK) > MAX_LEN_BYTES) begin
          err      = 1'b1;
          err_kind = ERR_TOO_LONG;
        end else if ((b & LEN_MASK) == 0) begin
          hdr = 1'b1;
        end else begin
          len_bytes_left = int'(b & LEN_MASK);
          cur_phase      = PH_LEN_MORE;
        end
      end
    end else if (cur_phase == PH_LEN_MORE) begin
      if (len_word[31:24] != 0) begin
        err      = 1'b1;
        err_kind = ERR_TOO_LONG;
      end else begin
        len_word = {len_word[23:0], b};
        if (len_bytes_left > 0) len_bytes_left = len_bytes_left - 1;
        if (len_bytes_left == 0) hdr = 1'b1;
      end
    end else begin
      ev    = EV_VALUE;
      vbyte = b;
      if (value_left > 0) value_left = value_left - 32'd1;
      if (value_left == 0) begin
        vlast     = 1'b1;
        complete  = 1'b1;
        cur_phase = PH_TAG_FIRST;
      end
    end

    // A finished header must fit inside its parent and inside the position range.
    if (hdr) begin
      end_pos = {1'b0, here} + 33'd1 + {1'b0, len_word};
      if (open_levels > 0 && end_pos > {1'b0, close_at[open_levels-1]}) begin
        err      = 1'b1;
        err_kind = ERR_OVERRUN;
      end else if (end_pos > 33'h0_FFFF_FFFF) begin
        err      = 1'b1;
        err_kind = ERR_TRUNC;
      end else if (hdr_constructed && open_levels >= MAX_DEPTH) begin
        err      = 1'b1;
        err_kind = ERR_TOO_DEEP;
      end else begin
        ev        = EV_HEADER;
        cur_phase = PH_TAG_FIRST;
        if (hdr_constructed) begin
          if (len_word == 0) begin
            // An empty container opens and closes on its own last header byte.
            closed   = 1;
            complete = 1'b1;
          end else begin
            close_at[open_levels] = end_pos[31:0];
            open_levels           = open_levels + 1;
          end
        end else if (len_word == 0) begin
          complete = 1'b1;
        end else begin
          value_left = len_word;
          cur_phase  = PH_VALUE;
        end
      end
    end

    // Every container whose end falls right after this byte closes here.
    if (!err && complete) begin
      while (open_levels > 0 && close_at[open_levels-1] == nxt) begin
        open_levels = open_levels - 1;
        closed      = closed + 1;
      end
    end

    if (last && !err) begin
      if (cur_phase != PH_TAG_FIRST || open_levels > 0) begin
        err      = 1'b1;
        err_kind = ERR_TRUNC;
      end else begin
        done = 1'b1;
      end
    end

    if (err) begin
      in_error     = 1'b1;
      r.event_res  = EV_ERROR;
      r.depth      = DEPTH_W'(dep);
      r.error_kind = err_kind;
    end else begin
      r.event_res = ev;
      if (ev == EV_HEADER) begin
        r.tag         = tag_word;
        r.tag_bytes   = 3'(tag_count);
        r.length      = len_word;
        r.constructed = hdr_constructed;
      end
      r.depth         = DEPTH_W'(dep);
      r.value_byte    = vbyte;
      r.value_last    = vlast;
      r.closed_levels = DEPTH_W'(closed);
      r.message_done  = done;
    end

    if (last) parser_idle();
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Message construction. Well-formed elements carry random tags, lengths and
  // content; a share of the messages is damaged afterwards or is plain noise.
  // ---------------------------------------------------------------------------
  function automatic bytes_t tag_field(logic constr, int n);
    bytes_t     f;
    logic [7:0] b;
    b = 8'($urandom_range(255));
    b = constr ? (b | CONS_BIT) : (b & ~CONS_BIT);
    if (n == 1) begin
      // All ones in the low five bits would announce further tag bytes.
      if ((b & TAG_NUM_MASK) == TAG_NUM_MASK) b = b & ~8'h01;
    end else begin
      b = b | TAG_NUM_MASK;
    end
    f.push_back(b);
    for (int i = 1; i < n; i++) begin
      b = 8'($urandom_range(127));
      if (i < n - 1) b = b | CONT_BIT;
      f.push_back(b);
    end
    return f;
  endfunction

  function automatic bytes_t len_field(int n);
    bytes_t f;
    int     nb;
    int     t;
    nb = 0;
    t  = n;
    while (t != 0) begin
      nb = nb + 1;
      t  = t >> 8;
    end
    if ($urandom_range(39) == 0) begin
      // A long form count the block must refuse.
      f.push_back(CONT_BIT | 8'($urandom_range(127, MAX_LEN_BYTES + 1)));
      return f;
    end
    if (n < 128 && $urandom_range(3) != 0) begin
      f.push_back(8'(n));
      return f;
    end
    // Long form, possibly padded with leading zero bytes.
    nb = $urandom_range(MAX_LEN_BYTES, nb);
    f.push_back(CONT_BIT | 8'(nb));
    for (int i = nb - 1; i >= 0; i--) f.push_back(8'(n >> (8 * i)));
    return f;
  endfunction

  // A chain nests one constructed element inside the next down to a primitive
  // leaf, which is how the depth limit gets reached and exceeded.
  function automatic bytes_t build_tlv(int lvl, logic chain);
    bytes_t body;
    logic   constr;
    int     n;
    int     pick;
    int     tb;
    if (chain) constr = lvl > 0;
    else constr = lvl > 0 && $urandom_range(99) < 35;
    if (constr) begin
      n = chain ? 1 : $urandom_range(3);
      repeat (n) body = {body, build_tlv(lvl - 1, chain)};
    end else begin
      pick = $urandom_range(99);
      if (pick < 95) n = $urandom_range(8);
      else if (pick < 99) n = $urandom_range(140, 9);
      else n = $urandom_range(300, 141);
      repeat (n) body.push_back(8'($urandom_range(255)));
    end
    tb = ($urandom_range(29) == 0) ? MAX_TAG_BYTES + 1 : $urandom_range(MAX_TAG_BYTES, 1);
    return {tag_field(constr, tb), len_field(body.size()), body};
  endfunction

  function automatic bytes_t make_message();
    bytes_t m;
    int     pick;
    int     at;
    if ($urandom_range(99) < 10) begin
      m = build_tlv($urandom_range(MAX_DEPTH + 1, MAX_DEPTH - 2), 1'b1);
    end else begin
      repeat ($urandom_range(3, 1)) m = {m, build_tlv($urandom_range(4), 1'b0)};
    end
    pick = $urandom_range(99);
    if (pick < 8 && m.size() > 1) begin
      m = m[0:$urandom_range(m.size() - 2)];
    end else if (pick < 14) begin
      at    = $urandom_range(m.size() - 1);
      m[at] = 8'($urandom_range(255));
    end else if (pick < 18) begin
      m.insert($urandom_range(m.size()), 8'($urandom_range(255)));
    end else if (pick < 22) begin
      m.delete();
      repeat ($urandom_range(12, 1)) m.push_back(8'($urandom_range(255)));
    end
    return m;
  endfunction

  function automatic void queue_msg(bytes_t m);
    stream_word_t w;
    foreach (m[i]) begin
      w.data = m[i];
      w.last = (i == m.size() - 1);
      byte_backlog.push_back(w);
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count = fail_count + 1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver. A word stays offered until it is taken; only between words does the
  // sender idle, so gaps land in headers, lengths and values alike.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (offering && in_took) offering = 1'b0;
    if (!offering && rst_n && byte_backlog.size() != 0 &&
        $urandom_range(99) >= send_idle_pct) begin
      cur_word = byte_backlog.pop_front();
      offering = 1'b1;
    end
    in_if.valid     <= offering;
    in_if.in_byte   <= cur_word.data;
    in_if.last_byte <= cur_word.last;
  end

  // Receiver. A hold-off request keeps ready low for a long stretch so that the
  // block fills both register stages and pushes back on the byte channel.
  always @(negedge clk) begin
    logic rdy;
    if (hold_req) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rdy       = 1'b0;
    end else begin
      rdy = $urandom_range(99) >= take_idle_pct;
    end
    out_if.ready <= rdy;
  end

  // ---------------------------------------------------------------------------
  // Monitor. At each rising edge a result word that is taken is checked against
  // the oldest expectation, and a byte word that is taken is run through the
  // parser state to queue its expected result. The watchdog counts cycles in
  // which work is outstanding but neither channel moves a word.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    res_t want;
    logic out_took;
    in_took  = rst_n && in_if.valid && in_if.ready;
    out_took = rst_n && out_if.valid && out_if.ready;
    if (out_took) begin
      if (pending_results.size() == 0) begin
        $error("result word arrived with no expectation waiting");
        fail_count = fail_count + 1;
      end else begin
        want = pending_results.pop_front();
        check_field("event_res",     32'(want.event_res),     32'(out_if.event_res));
        check_field("tag",           want.tag,                out_if.tag);
        check_field("tag_bytes",     32'(want.tag_bytes),     32'(out_if.tag_bytes));
        check_field("length",        want.length,             out_if.length);
        check_field("constructed",   32'(want.constructed),   32'(out_if.constructed));
        check_field("depth",         32'(want.depth),         32'(out_if.depth));
        check_field("value_byte",    32'(want.value_byte),    32'(out_if.value_byte));
        check_field("value_last",    32'(want.value_last),    32'(out_if.value_last));
        check_field("closed_levels", 32'(want.closed_levels), 32'(out_if.closed_levels));
        check_field("error_kind",    32'(want.error_kind),    32'(out_if.error_kind));
        check_field("message_done",  32'(want.message_done),  32'(out_if.message_done));
      end
    end
    if (in_took) pending_results.push_back(parse_byte(in_if.in_byte, in_if.last_byte));

    if (in_took || out_took ||
        (byte_backlog.size() == 0 && !offering && pending_results.size() == 0)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles = stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("ber_tlv_stream_parser: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus. Three stages with different idling: the sender idles lightly while
  // the receiver idles heavily, then the reverse, then neither. The directed
  // messages go first. Each stage ends with the sender holding back until every
  // expected result word has come out.
  // ---------------------------------------------------------------------------
  initial begin
    int           fill;
    bytes_t       msg;
    stream_word_t w;
    in_if.valid     = 1'b0;
    in_if.in_byte   = '0;
    in_if.last_byte = 1'b0;
    out_if.ready    = 1'b0;
    parser_idle();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int stage = 0; stage < 3; stage++) begin
      case (stage)
        0: begin
          send_idle_pct = 10;
          take_idle_pct = 76;
        end
        1: begin
          send_idle_pct = 76;
          take_idle_pct = 10;
        end
        default: begin
          send_idle_pct = 0;
          take_idle_pct = 0;
        end
      endcase
      if (stage == 0) begin
        foreach (DIRECTED_WORDS[i]) begin
          w.data = DIRECTED_WORDS[i][7:0];
          w.last = DIRECTED_WORDS[i][8];
          byte_backlog.push_back(w);
        end
      end
      // The long receiver hold-off opens the first and the last stage, while the
      // sender keeps offering words.
      if (stage != 1) hold_req = 1'b1;
      fill = 0;
      while (fill < RANDOM_BYTES_PER_STAGE) begin
        msg  = make_message();
        fill = fill + msg.size();
        queue_msg(msg);
      end
      while (byte_backlog.size() != 0 || offering || pending_results.size() != 0)
        @(posedge clk);
    end

    // Give a stray extra result word a chance to show up before deciding.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ber_tlv_stream_parser: match");
    end else begin
      $display("ber_tlv_stream_parser: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/btsp_pkg.sv
src/btsp_ifs.sv
src/btsp_in_stage.sv
src/btsp_stack.sv
src/btsp_core.sv
src/btsp_out_stage.sv
src/ber_tlv_stream_parser.sv
tb/sv/tb_top.sv
